[sv/nca_pkg.sv]
// Package for the nearest-centre assignment unit.
// Holds sizes, derived widths, item and register codes, and shared types.
// No dependencies.
package nca_pkg;

	// Sizing
	localparam int MAX_CENTERS = 8;
	localparam int DIMS        = 4;
	localparam int COORD_BITS  = 16;

	// Fixed field widths of the channels and registers
	localparam int IN_COORDS  = 4;
	localparam int IN_W       = 16;
	localparam int KIND_W     = 2;
	localparam int SLOT_W     = 3;
	localparam int IDX_OUT_W  = 3;
	localparam int MIN_OUT_W  = 34;
	localparam int COST_W     = 64;
	localparam int CENTERS_W  = 4;
	localparam int DIMSREG_W  = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Derived widths
	localparam int LOG_C  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int POW    = 1 << LOG_C;
	localparam int CIDX_W = LOG_C;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = SQ_W + ((DIMS > 1) ? $clog2(DIMS) : 0);
	localparam int DIST_W = (SUM_W > COST_W) ? COST_W : SUM_W;
	// accept -> lane stages (3) -> compare tree (LOG_C)
	localparam int LAT    = 3 + LOG_C;
	localparam int CNT_W  = $clog2(LAT + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [DIMS-1:0] vec_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		logic              used;
		logic [CIDX_W-1:0] idx;
		dist_t             sq_d;
	} cand_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_POINT = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTERS = 1'd0,
		REG_DIMS    = 1'd1
	} reg_idx_t;

	// Read an input field as a COORD_BITS-wide two's complement value
	function automatic coord_t to_coord(input logic [IN_W-1:0] raw);
		logic [COORD_BITS+IN_W-1:0] ext;
		ext = {{COORD_BITS{1'b0}}, raw};
		return coord_t'(ext[COORD_BITS-1:0]);
	endfunction

endpackage

[sv/nca_if.sv]
// Channel interfaces of the nearest-centre assignment unit.
// Depends on nca_pkg for field widths.
interface nca_item_if;
	import nca_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [SLOT_W-1:0]        center_slot;
	logic signed [IN_W-1:0]   coord_0;
	logic signed [IN_W-1:0]   coord_1;
	logic signed [IN_W-1:0]   coord_2;
	logic signed [IN_W-1:0]   coord_3;

	modport source (output valid, kind, center_slot, coord_0, coord_1, coord_2, coord_3,
		input ready);
	modport sink (input valid, kind, center_slot, coord_0, coord_1, coord_2, coord_3,
		output ready);
endinterface

interface nca_result_if;
	import nca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] cluster_index;
	logic [MIN_OUT_W-1:0] min_sq_distance;
	logic [COST_W-1:0]    total_cost;

	modport source (output valid, cluster_index, min_sq_distance, total_cost, input ready);
	modport sink (input valid, cluster_index, min_sq_distance, total_cost, output ready);
endinterface

[sv/nca_lane.sv]
// One distance lane: squared Euclidean distance of a point to one centre.
// Three register stages: magnitude, square, saturating sum. Depends on nca_pkg.
module nca_lane (
	input  logic          clk,
	input  nca_pkg::vec_t point,
	input  nca_pkg::vec_t center,
	input  logic [nca_pkg::DIMS-1:0] dim_use,
	output nca_pkg::dist_t sq_out
);
	import nca_pkg::*;

	logic [COORD_BITS-1:0] mag_s1 [DIMS];
	logic [SQ_W-1:0]       sq_s2  [DIMS];
	logic [SUM_W-1:0]      sum;
	dist_t                 dist_s3;

	// Take absolute differences, zeroing unused coordinates
	for (genvar d = 0; d < DIMS; d++) begin : g_dim
		logic signed [COORD_BITS:0] diff;
		logic signed [COORD_BITS:0] neg;
		assign diff = {point[d][COORD_BITS-1], point[d]} - {center[d][COORD_BITS-1], center[d]};
		assign neg  = -diff;
		always_ff @(posedge clk) begin
			if (!dim_use[d]) begin
				mag_s1[d] <= '0;
			end else if (diff[COORD_BITS]) begin
				mag_s1[d] <= neg[COORD_BITS-1:0];
			end else begin
				mag_s1[d] <= diff[COORD_BITS-1:0];
			end
		end

		// Square each magnitude
		always_ff @(posedge clk) begin
			sq_s2[d] <= mag_s1[d] * mag_s1[d];
		end
	end

	// Add the squares
	always_comb begin
		sum = '0;
		for (int d = 0; d < DIMS; d++) begin
			sum = sum + SUM_W'(sq_s2[d]);
		end
	end

	// Saturate to the cost width where the sum can exceed it
	if (SUM_W > COST_W) begin : g_sat
		always_ff @(posedge clk) begin
			dist_s3 <= (|sum[SUM_W-1:COST_W]) ? '1 : sum[COST_W-1:0];
		end
	end else begin : g_nosat
		always_ff @(posedge clk) begin
			dist_s3 <= sum;
		end
	end

	assign sq_out = dist_s3;

endmodule

[sv/nca_merge.sv]
// Merging stage: registered compare tree over the lane distances.
// One level per cycle; the lower index wins ties. Depends on nca_pkg.
module nca_merge (
	input  logic           clk,
	input  nca_pkg::dist_t lane_d [nca_pkg::MAX_CENTERS],
	input  logic [nca_pkg::MAX_CENTERS-1:0] center_use,
	output nca_pkg::cand_t best
);
	import nca_pkg::*;

	cand_t leaf [POW];
	cand_t node_q [1:POW-1];

	// Keep the left (lower index) candidate unless the right one is strictly nearer
	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (b.used && (!a.used || (b.sq_d < a.sq_d))) begin
			return b;
		end
		return a;
	endfunction

	// Build leaves; padding leaves are never used
	for (genvar i = 0; i < POW; i++) begin : g_leaf
		if (i < MAX_CENTERS) begin : g_real
			assign leaf[i] = '{used: center_use[i], idx: CIDX_W'(i), sq_d: lane_d[i]};
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	// Register every tree node, heap order: node n has children 2n and 2n+1
	for (genvar n = 1; n < POW; n++) begin : g_node
		if (2 * n >= POW) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[n] <= pick(leaf[2*n-POW], leaf[2*n+1-POW]);
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[n] <= pick(node_q[2*n], node_q[2*n+1]);
			end
		end
	end

	assign best = node_q[1];

endmodule

[sv/nearest_center_assignment_unit.sv]
// Nearest-centre assignment unit: load centres, classify points, clear the running cost.
// A point passes from transfer in to result through one capture register, three lane stages,
// the registered compare-tree levels and one output register.
// One point in flight at a time: no item of any kind is taken until its result enters the output register;
// load, clear and ignored items give no result and do not hold off the next item.
// Reset (arst_n low) clears centres, cost, control and restores 8 centres, 4 dimensions.
module nearest_center_assignment_unit (
	input  logic clk,
	input  logic arst_n,
	nca_item_if.sink     item,
	nca_result_if.source result,
	input  logic cfg_we,
	input  logic [nca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nca_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nca_pkg::*;

	logic [CENTERS_W-1:0] centers_q;
	logic [DIMSREG_W-1:0] dims_q;
	vec_t                 store_q [MAX_CENTERS];
	vec_t                 item_vec;
	vec_t                 point_q;
	logic [IN_W-1:0]      raw [IN_COORDS];
	logic [DIMS-1:0]        dim_use;
	logic [MAX_CENTERS-1:0] center_use;
	dist_t                lane_d [MAX_CENTERS];
	cand_t                best;
	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [COST_W-1:0]    cost_q;
	logic [COST_W:0]      cost_sum;
	logic [COST_W-1:0]    cost_next;
	logic [COST_W-1:0]    dist_ext;
	logic                 accept;
	logic                 finish;
	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [MIN_OUT_W-1:0] out_min_q;
	logic [COST_W-1:0]    out_cost_q;

	assign accept = item.valid && item.ready;
	assign item.ready = !busy_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centers_q <= CENTERS_W'(8);
			dims_q    <= DIMSREG_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CENTERS: centers_q <= cfg_data[CENTERS_W-1:0];
				REG_DIMS:    dims_q    <= cfg_data[DIMSREG_W-1:0];
				default:     ;
			endcase
		end
	end

	// Lane and coordinate enables; zero counts act as one, large counts clamp
	for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_cuse
		assign center_use[i] = (i == 0) || (32'(centers_q) > i);
	end
	for (genvar d = 0; d < DIMS; d++) begin : g_duse
		assign dim_use[d] = (d == 0) || (32'(dims_q) > d);
	end

	// Unpack the item coordinates; those past the fourth are zero
	assign raw[0] = item.coord_0;
	assign raw[1] = item.coord_1;
	assign raw[2] = item.coord_2;
	assign raw[3] = item.coord_3;
	for (genvar d = 0; d < DIMS; d++) begin : g_vec
		if (d < IN_COORDS) begin : g_in
			assign item_vec[d] = to_coord(raw[d]);
		end else begin : g_zero
			assign item_vec[d] = '0;
		end
	end

	// Centre store, written by load items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CENTERS; i++) begin
				store_q[i] <= '0;
			end
		end else if (accept && (item.kind == KIND_LOAD)) begin
			for (int i = 0; i < MAX_CENTERS; i++) begin
				if (32'(item.center_slot) == i) begin
					store_q[i] <= item_vec;
				end
			end
		end
	end

	// Hold the point under test
	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_POINT)) begin
			point_q <= item_vec;
		end
	end

	// Distance lanes
	for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_lane
		nca_lane u_lane (
			.clk     (clk),
			.point   (point_q),
			.center  (store_q[i]),
			.dim_use (dim_use),
			.sq_out  (lane_d[i])
		);
	end

	nca_merge u_merge (
		.clk        (clk),
		.lane_d     (lane_d),
		.center_use (center_use),
		.best       (best)
	);

	// Track the point through the lanes and tree; drop busy once the result moves out
	assign finish = busy_q && (cnt_q == CNT_W'(LAT)) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept && (item.kind == KIND_POINT)) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (busy_q && (cnt_q != CNT_W'(LAT))) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Saturating running cost
	assign dist_ext  = COST_W'(best.sq_d);
	assign cost_sum  = {1'b0, cost_q} + {1'b0, dist_ext};
	assign cost_next = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
		end else if (accept && (item.kind == KIND_CLEAR)) begin
			cost_q <= '0;
		end else if (finish) begin
			cost_q <= cost_next;
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_idx_q  <= IDX_OUT_W'(best.idx);
			out_min_q  <= dist_ext[MIN_OUT_W-1:0];
			out_cost_q <= cost_next;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.cluster_index   = out_idx_q;
	assign result.min_sq_distance = out_min_q;
	assign result.total_cost      = out_cost_q;

endmodule

[sv/nca_checker.sv]
// Port-level checks for the nearest-centre assignment unit, bound to the top level.
// Depends on nca_pkg and nearest_center_assignment_unit.
module nca_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [nca_pkg::KIND_W-1:0] in_kind,
	input logic out_valid,
	input logic out_ready,
	input logic [nca_pkg::MIN_OUT_W-1:0] out_min,
	input logic [nca_pkg::COST_W-1:0]    out_cost
);
	import nca_pkg::*;

	// A waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_min) && $stable(out_cost))
		else $error("result changed while stalled");

	// A point transfer blocks the next item
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == KIND_POINT) |=> !in_ready)
		else $error("item accepted while a point is in flight");

	// A new result appears only after a busy period
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a point in flight");

	// Running cost includes the current minimum
	a_cost_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_cost >= COST_W'(out_min)))
		else $error("running cost below its own minimum");

endmodule

bind nearest_center_assignment_unit nca_checker u_nca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_kind   (item.kind),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_min   (result.min_sq_distance),
	.out_cost  (result.total_cost)
);
